/* src/lis_pkg.sv */
// ----------------------------------------------------------------------------
// lis_pkg
// Shared types and constants for the longest increasing subsequence block.
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int DATA_W          = 32;
  localparam int LEN_OUT_W       = 7;
  localparam int MAX_LEN_DEFAULT = 64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_TOP,
    S_TRACE_RD,
    S_TRACE_WAIT,
    S_EMIT_PATH,
    S_EMIT_VAL,
    S_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  element;
    logic [LEN_OUT_W-1:0]      subsequence_length;
    logic                      last_of_run;
  } result_t;

endpackage

/* src/lis_if.sv */
// ----------------------------------------------------------------------------
// lis_in_if / lis_out_if
// Valid/ready channels for sequence items and subsequence results.
// ----------------------------------------------------------------------------
interface lis_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [lis_pkg::DATA_W-1:0] value;
  logic                             is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface lis_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lis_pkg::DATA_W-1:0]    element;
  logic [lis_pkg::LEN_OUT_W-1:0]        subsequence_length;
  logic                                last_of_run;

  modport source (output valid, output element, output subsequence_length,
                  output last_of_run, input ready);
  modport sink   (input valid, input element, input subsequence_length,
                  input last_of_run, output ready);
endinterface

/* src/lis_out_stage.sv */
// ----------------------------------------------------------------------------
// lis_out_stage
// Output register: holds one result until its transfer completes.
// ----------------------------------------------------------------------------
module lis_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lis_pkg::result_t  data,
  output logic              free,
  lis_out_if.source         results
);

  logic             valid;
  lis_pkg::result_t hold;

  assign free = !valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= data;
    end
  end

  assign results.valid              = valid;
  assign results.element            = hold.element;
  assign results.subsequence_length = hold.subsequence_length;
  assign results.last_of_run        = hold.last_of_run;

endmodule

/* src/longest_increasing_subsequence.sv */
// ----------------------------------------------------------------------------
// longest_increasing_subsequence
// Quadratic DP over a stored sequence; traces back and emits the longest
// strictly increasing subsequence after the last item.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                         end marker
//  items     in    value[31:0] signed                              is_last
//  results   out   element[31:0] signed, subsequence_length[6:0]   last_of_run
//
//  Each item at position n < MAX_LEN is scanned with one entry-memory read per
//  earlier position, then written. The last item adds a maximum search over
//  the stored entries, a traceback read per element and an output step per
//  element. Items past capacity are taken without being stored.
//  Reset clears state and the item count; memories are not cleared.
//  A stalled results channel stops the output loop; items wait for idle.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence #(
  parameter int MAX_LEN = lis_pkg::MAX_LEN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  lis_in_if.sink     items,
  lis_out_if.source  results
);

  localparam int IW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int LW = CW;

  typedef struct packed {
    logic signed [lis_pkg::DATA_W-1:0] value;
    logic [LW-1:0]                     len;
    logic [IW-1:0]                     pred;
  } entry_t;

  entry_t        mem [MAX_LEN];
  entry_t        rd;
  logic [IW-1:0] path_mem [MAX_LEN];
  logic [IW-1:0] path_rd;

  lis_pkg::state_t state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] kcnt;
  logic          rd_valid;
  logic signed [lis_pkg::DATA_W-1:0] value_q;
  logic          last_q;
  logic [LW-1:0] best;
  logic [IW-1:0] pred;
  logic [IW-1:0] top;
  logic [LW-1:0] toplen;
  logic [LW-1:0] len;
  logic [IW-1:0] pos;

  logic          issue;
  logic          scan_done;
  logic          mem_we;
  logic [IW-1:0] mem_raddr;
  logic          path_we;
  logic          load;
  logic          out_free;
  logic          final_elem;
  lis_pkg::result_t res;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lis_pkg::S_IDLE: begin
        if (items.valid) begin
          if (count < CW'(MAX_LEN)) begin
            state_next = lis_pkg::S_SCAN;
          end else if (items.is_last) begin
            state_next = lis_pkg::S_TOP;
          end
        end
      end
      lis_pkg::S_SCAN:       if (scan_done) state_next = lis_pkg::S_WRITE;
      lis_pkg::S_WRITE:      state_next = last_q ? lis_pkg::S_TOP : lis_pkg::S_IDLE;
      lis_pkg::S_TOP:        if (scan_done) state_next = lis_pkg::S_TRACE_RD;
      lis_pkg::S_TRACE_RD:   state_next = lis_pkg::S_TRACE_WAIT;
      lis_pkg::S_TRACE_WAIT: begin
        state_next = (kcnt == '0) ? lis_pkg::S_EMIT_PATH : lis_pkg::S_TRACE_RD;
      end
      lis_pkg::S_EMIT_PATH:  state_next = lis_pkg::S_EMIT_VAL;
      lis_pkg::S_EMIT_VAL:   state_next = lis_pkg::S_EMIT_OUT;
      lis_pkg::S_EMIT_OUT: begin
        if (out_free) begin
          state_next = final_elem ? lis_pkg::S_IDLE : lis_pkg::S_EMIT_PATH;
        end
      end
      default:               state_next = lis_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    items.ready = 1'b0;
    issue       = 1'b0;
    mem_we      = 1'b0;
    path_we     = 1'b0;
    mem_raddr   = '0;
    load        = 1'b0;
    unique case (state)
      lis_pkg::S_IDLE:       items.ready = 1'b1;
      lis_pkg::S_SCAN,
      lis_pkg::S_TOP: begin
        issue     = (idx < count);
        mem_raddr = idx[IW-1:0];
      end
      lis_pkg::S_WRITE:      mem_we = 1'b1;
      lis_pkg::S_TRACE_RD: begin
        mem_raddr = pos;
        path_we   = 1'b1;
      end
      lis_pkg::S_TRACE_WAIT: mem_raddr = pos;
      lis_pkg::S_EMIT_PATH:  mem_raddr = path_rd;
      lis_pkg::S_EMIT_VAL:   mem_raddr = path_rd;
      lis_pkg::S_EMIT_OUT: begin
        mem_raddr = path_rd;
        load      = out_free;
      end
      default: ;
    endcase
  end

  assign scan_done  = !issue && !rd_valid;
  assign final_elem = (CW'(kcnt + 1'b1) == len);

  // entry memory: {value, chain length, predecessor}
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IW-1:0]] <= '{value: value_q, len: best, pred: pred};
    end
    rd <= mem[mem_raddr];
  end

  // traceback path memory
  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[IW'(kcnt - 1'b1)] <= pos;
    end
    path_rd <= path_mem[kcnt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lis_pkg::S_IDLE;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (state == lis_pkg::S_WRITE) begin
        count <= count + 1'b1;
      end else if (load && final_elem) begin
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      lis_pkg::S_IDLE: begin
        value_q <= items.value;
        last_q  <= items.is_last;
        idx     <= '0;
        best    <= LW'(1);
        pred    <= '0;
        toplen  <= '0;
        top     <= '0;
      end
      lis_pkg::S_SCAN: begin
        if (issue) idx <= idx + 1'b1;
        if (rd_valid && ($signed(rd.value) < $signed(value_q)) && (rd.len >= best)) begin
          best <= LW'(rd.len + 1'b1);
          pred <= IW'(idx - 1'b1);
        end
      end
      lis_pkg::S_WRITE: idx <= '0;
      lis_pkg::S_TOP: begin
        if (issue) idx <= idx + 1'b1;
        if (rd_valid && (rd.len > toplen)) begin
          toplen <= rd.len;
          top    <= IW'(idx - 1'b1);
        end
        if (scan_done) begin
          kcnt <= toplen;
          len  <= toplen;
          pos  <= top;
        end
      end
      lis_pkg::S_TRACE_RD:   kcnt <= kcnt - 1'b1;
      lis_pkg::S_TRACE_WAIT: pos  <= rd.pred;
      lis_pkg::S_EMIT_OUT:   if (load) kcnt <= kcnt + 1'b1;
      default: ;
    endcase
  end

  assign res.element            = rd.value;
  assign res.subsequence_length = lis_pkg::LEN_OUT_W'(len);
  assign res.last_of_run        = final_elem;

  lis_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .data    (res),
    .free    (out_free),
    .results (results)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_LEN))
    else $error("item count beyond capacity");

  a_trace_descends: assert property (@(posedge clk) disable iff (rst)
    (state == lis_pkg::S_TRACE_RD && $past(state) == lis_pkg::S_TRACE_WAIT)
      |-> (pos < $past(pos)))
    else $error("predecessor not below its position");

  a_trace_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == lis_pkg::S_TRACE_RD) |-> (kcnt != '0))
    else $error("traceback with empty chain");

  a_chain_bound: assert property (@(posedge clk) disable iff (rst)
    (state == lis_pkg::S_WRITE) |-> ((best != '0) && (best <= count + 1'b1)))
    else $error("chain length exceeds position");

endmodule

/* dv/longest_increasing_subsequence_tb.sv */
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_tb
// Feeds sequences of signed values through the items channel and checks every
// emitted subsequence element against a quadratic-DP predictor kept in the
// bench, or the table for typed rows. A short directed table runs first
// (extremes, ties, decreasing and sign-crossing runs), then random sequences
// including a full and an overflowing one. Both channels stall at random.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEQ_DEPTH    = lis_pkg::MAX_LEN_DEFAULT;
  localparam int RANDOM_ITEMS = 250;
  // worst quiet stretch: 64-entry search and traceback plus long stalls
  localparam int IDLE_LIMIT   = 3000;

  typedef struct packed {
    logic signed [lis_pkg::DATA_W-1:0] value;
    logic                              is_last;
    logic                              typed;
    logic signed [lis_pkg::DATA_W-1:0] want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 20;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000},
    '{32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff},
    '{32'sd7,         1'b0, 1'b0, 32'sd0},
    '{32'sd7,         1'b0, 1'b0, 32'sd0},
    '{32'sd7,         1'b1, 1'b1, 32'sd7},
    '{32'sd3,         1'b0, 1'b0, 32'sd0},
    '{32'sd2,         1'b0, 1'b0, 32'sd0},
    '{32'sd1,         1'b1, 1'b1, 32'sd3},
    '{-32'sd5,        1'b0, 1'b0, 32'sd0},
    '{-32'sd1,        1'b0, 1'b0, 32'sd0},
    '{32'sd0,         1'b0, 1'b0, 32'sd0},
    '{32'sh7fff_ffff, 1'b1, 1'b0, 32'sd0},
    '{32'sd1,         1'b0, 1'b0, 32'sd0},
    '{32'sd5,         1'b0, 1'b0, 32'sd0},
    '{32'sd3,         1'b0, 1'b0, 32'sd0},
    '{32'sd4,         1'b0, 1'b0, 32'sd0},
    '{32'sd6,         1'b0, 1'b0, 32'sd0},
    '{32'sd2,         1'b1, 1'b0, 32'sd0},
    '{32'sh7fff_ffff, 1'b0, 1'b0, 32'sd0},
    '{32'sh8000_0000, 1'b1, 1'b1, 32'sh7fff_ffff}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  lis_in_if  items_if ();
  lis_out_if results_if ();

  longest_increasing_subsequence #(
    .MAX_LEN (SEQ_DEPTH)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  // predictor state
  logic signed [lis_pkg::DATA_W-1:0] seen_values [SEQ_DEPTH];
  logic [lis_pkg::LEN_OUT_W-1:0]     best_len    [SEQ_DEPTH];
  logic [5:0]                        back_link   [SEQ_DEPTH];
  int                                held = 0;

  lis_pkg::result_t traced_chain[$];
  lis_pkg::result_t pending_elements[$];

  int errors      = 0;
  int sent_items  = 0;
  int idle_cycles = 0;
  bit steady      = 1'b0;

  function automatic void advance_chain(input logic signed [lis_pkg::DATA_W-1:0] v,
                                        input logic last);
    int best;
    int link;
    int top;
    int len;
    int pos;
    int path [SEQ_DEPTH];
    lis_pkg::result_t r;
    traced_chain.delete();
    if (held < SEQ_DEPTH) begin
      best = 1;
      link = 0;
      for (int j = 0; j < held; j++) begin
        if (v > seen_values[j] && int'(best_len[j]) + 1 > best) begin
          best = int'(best_len[j]) + 1;
          link = j;
        end
      end
      seen_values[held] = v;
      best_len[held]    = lis_pkg::LEN_OUT_W'(best);
      back_link[held]   = 6'(link);
      held++;
    end
    if (last) begin
      top = 0;
      for (int k = 1; k < held; k++) begin
        if (best_len[k] > best_len[top]) begin
          top = k;
        end
      end
      len = int'(best_len[top]);
      pos = top;
      for (int k = len; k > 0; k--) begin
        path[k-1] = pos;
        pos = int'(back_link[pos]);
      end
      for (int k = 0; k < len; k++) begin
        r.element            = seen_values[path[k]];
        r.subsequence_length = lis_pkg::LEN_OUT_W'(len);
        r.last_of_run        = (k == len - 1);
        traced_chain = {traced_chain, r};
      end
      held = 0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic logic signed [lis_pkg::DATA_W-1:0] pick_value(input int mode,
                                                                    input int pos);
    case (mode)
      0: return $urandom;
      1: return int'($urandom_range(0, 40)) - 20;
      2: return -2000 + pos * 50 + int'($urandom_range(0, 20));
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return -32'sd1;
          3: return 32'sd0;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic send_item(input logic signed [lis_pkg::DATA_W-1:0] v, input logic last,
                           input logic typed,
                           input logic signed [lis_pkg::DATA_W-1:0] want);
    int gap;
    lis_pkg::result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_if.valid   <= 1'b1;
    items_if.value   <= v;
    items_if.is_last <= last;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    advance_chain(v, last);
    if (typed && last) begin
      r.element            = want;
      r.subsequence_length = lis_pkg::LEN_OUT_W'(1);
      r.last_of_run        = 1'b1;
      pending_elements = {pending_elements, r};
    end else begin
      foreach (traced_chain[k]) pending_elements = {pending_elements, traced_chain[k]};
    end
    sent_items++;
  endtask

  task automatic send_sequence(input int len, input int mode);
    for (int i = 0; i < len; i++) begin
      send_item(pick_value(mode, i), i == len - 1, 1'b0, '0);
    end
  endtask

  task automatic hold_until_drained();
    items_if.valid <= 1'b0;
    do @(posedge clk); while (pending_elements.size() != 0);
  endtask

  // results side: random backpressure
  initial begin
    int gap;
    int burst;
    results_if.ready = 1'b0;
    wait (!rst);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        results_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      burst = int'($urandom_range(1, 12));
      repeat (burst) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    lis_pkg::result_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_elements.size() == 0) begin
        report_mismatch($sformatf("unexpected element %0d", results_if.element));
      end else begin
        want = pending_elements.pop_front();
        if (results_if.element !== want.element)
          report_mismatch($sformatf("element %0d, want %0d",
                                    results_if.element, want.element));
        if (results_if.subsequence_length !== want.subsequence_length)
          report_mismatch($sformatf("subsequence_length %0d, want %0d",
                                    results_if.subsequence_length,
                                    want.subsequence_length));
        if (results_if.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %0b, want %0b",
                                    results_if.last_of_run, want.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (items_if.valid && items_if.ready) ||
        (results_if.valid && results_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAIL longest_increasing_subsequence");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int len;
    items_if.valid   = 1'b0;
    items_if.value   = '0;
    items_if.is_last = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(DIRECTED[r].value, DIRECTED[r].is_last, DIRECTED[r].typed,
                DIRECTED[r].want);
    end
    hold_until_drained();

    // full-length chain, then extra items past capacity ending the run
    steady = 1'b1;
    send_sequence(70, 2);
    steady = 1'b0;
    send_sequence(SEQ_DEPTH, 1);
    hold_until_drained();

    while (sent_items < DIRECTED_ROWS + RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 99) < 80) ? int'($urandom_range(1, 10))
                                         : int'($urandom_range(11, 24));
      send_sequence(len, int'($urandom_range(0, 3)));
      if ($urandom_range(0, 5) == 0) hold_until_drained();
    end
    steady = 1'b0;

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_elements.size() == 0) begin
      $display("PASS longest_increasing_subsequence");
    end else begin
      $display("FAIL longest_increasing_subsequence");
    end
    $finish;
  end

endmodule

/* sim.f */
src/lis_pkg.sv
src/lis_if.sv
src/lis_out_stage.sv
src/longest_increasing_subsequence.sv
dv/longest_increasing_subsequence_tb.sv
